/* rtl/buvs_pkg.sv */
// ----------------------------------------------------------------------------
// buvs_pkg
// Shared types and constants for the battery undervoltage supervisor.
// ----------------------------------------------------------------------------
package buvs_pkg;

  localparam int unsigned MEAS_W    = 16;
  localparam int unsigned TIMEOUT_W = 20;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 20;

  localparam logic [MEAS_W-1:0]    LOW_THRESHOLD_RST  = 16'h6fb4;
  localparam logic [MEAS_W-1:0]    HIGH_THRESHOLD_RST = 16'h9133;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST  = 20'd30000;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE = 2'd0,
    OP_TICK   = 2'd1,
    OP_TOUCH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD  = 2'd0,
    CFG_HIGH_THRESHOLD = 2'd1,
    CFG_TIMEOUT_TICKS  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [MEAS_W-1:0]    low_threshold;
    logic [MEAS_W-1:0]    high_threshold;
    logic [TIMEOUT_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic enter_low_power;
    logic system_reset;
    logic timer_running;
    logic low_power_mode;
  } result_t;

endpackage

/* rtl/buvs_intf.sv */
// ----------------------------------------------------------------------------
// buvs_intf
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface buvs_in_if;
  logic                           valid;
  logic                           ready;
  logic [buvs_pkg::OP_W-1:0]      operation;
  logic [buvs_pkg::MEAS_W-1:0]    measurement;

  modport source (output valid, output operation, output measurement, input ready);
  modport sink   (input valid, input operation, input measurement, output ready);
endinterface

interface buvs_out_if;
  logic valid;
  logic ready;
  logic enter_low_power;
  logic system_reset;
  logic timer_running;
  logic low_power_mode;

  modport source (output valid, output enter_low_power, output system_reset,
                  output timer_running, output low_power_mode, input ready);
  modport sink   (input valid, input enter_low_power, input system_reset,
                  input timer_running, input low_power_mode, output ready);
endinterface

interface buvs_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [buvs_pkg::CFG_IDX_W-1:0] index;
  logic [buvs_pkg::CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/battery_undervoltage_supervisor.sv */
// ----------------------------------------------------------------------------
// battery_undervoltage_supervisor
// Low battery cutoff with hysteresis, a hold-off timer and touch wake.
// ----------------------------------------------------------------------------
// Takes one item (sample, tick, touch or none) per clock and returns one result
// per item, in the cycle after acceptance, from an output register. The whole state
// update is a pair of 16-bit compares and a 20-bit decrement, so throughput is
// one item per cycle; while the result register is full and not taken, the
// input stalls. Register writes: index 0 low threshold, 1 high threshold,
// 2 timeout in ticks (0 acts as 1); other indexes are ignored. Write them only
// while no result is pending.
module battery_undervoltage_supervisor (
  input logic        clk,
  input logic        rst,
  buvs_in_if.sink    in_ch,
  buvs_out_if.source out_ch,
  buvs_cfg_if.sink   cfg_ch
);

  buvs_pkg::cfg_t    cfg;
  buvs_pkg::result_t res;
  buvs_pkg::result_t out_res;
  logic              out_valid;
  logic              accept;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_threshold  <= buvs_pkg::LOW_THRESHOLD_RST;
      cfg.high_threshold <= buvs_pkg::HIGH_THRESHOLD_RST;
      cfg.timeout_ticks  <= buvs_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_ch.valid) begin
      unique case (buvs_pkg::cfg_idx_t'(cfg_ch.index))
        buvs_pkg::CFG_LOW_THRESHOLD:
          cfg.low_threshold <= cfg_ch.data[buvs_pkg::MEAS_W-1:0];
        buvs_pkg::CFG_HIGH_THRESHOLD:
          cfg.high_threshold <= cfg_ch.data[buvs_pkg::MEAS_W-1:0];
        buvs_pkg::CFG_TIMEOUT_TICKS:
          cfg.timeout_ticks <= cfg_ch.data[buvs_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  buvs_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (accept),
    .operation   (in_ch.operation),
    .measurement (in_ch.measurement),
    .cfg         (cfg),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res <= res;
    end
  end

  assign out_ch.valid           = out_valid;
  assign out_ch.enter_low_power = out_res.enter_low_power;
  assign out_ch.system_reset    = out_res.system_reset;
  assign out_ch.timer_running   = out_res.timer_running;
  assign out_ch.low_power_mode  = out_res.low_power_mode;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted transaction produced no result");

  a_reset_clears_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.system_reset |-> !out_res.timer_running && !out_res.low_power_mode)
    else $error("reset request left state active");

  a_entry_sets_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.enter_low_power && !out_res.system_reset |-> out_res.low_power_mode)
    else $error("low power entry without low power mode");

  a_result_held_while_stalled: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ch.ready |=> out_valid && $stable(out_res))
    else $error("pending result changed before it was taken");

endmodule

/* rtl/buvs_core.sv */
// ----------------------------------------------------------------------------
// buvs_core
// Supervisor state and its combinational update for one accepted item.
// ----------------------------------------------------------------------------
module buvs_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic [buvs_pkg::OP_W-1:0]           operation,
  input  logic [buvs_pkg::MEAS_W-1:0]         measurement,
  input  buvs_pkg::cfg_t                      cfg,
  output buvs_pkg::result_t                   res
);

  logic                             in_low_power;
  logic                             hold_active;
  logic [buvs_pkg::TIMEOUT_W-1:0]   hold_remaining;
  logic                             hold_expired;
  logic                             touch_armed;

  logic                             in_low_power_next;
  logic                             hold_active_next;
  logic [buvs_pkg::TIMEOUT_W-1:0]   hold_remaining_next;
  logic                             hold_expired_next;
  logic                             touch_armed_next;
  logic                             entered;
  logic                             sys_reset;
  logic                             is_low;
  logic                             is_high;

  assign is_low  = measurement < cfg.low_threshold;
  assign is_high = measurement > cfg.high_threshold;

  always_comb begin
    in_low_power_next   = in_low_power;
    hold_active_next    = hold_active;
    hold_remaining_next = hold_remaining;
    hold_expired_next   = hold_expired;
    touch_armed_next    = touch_armed;
    entered             = 1'b0;
    sys_reset           = 1'b0;

    case (buvs_pkg::op_t'(operation))
      buvs_pkg::OP_SAMPLE: begin
        if (is_low) begin
          touch_armed_next = 1'b1;
          if (!in_low_power) begin
            if (hold_expired) begin
              in_low_power_next = 1'b1;
              entered           = 1'b1;
            end
            if (!hold_active && !hold_expired) begin
              hold_active_next    = 1'b1;
              hold_remaining_next = cfg.timeout_ticks;
            end
          end
        end
        // inverted thresholds: high test sees the low branch's result
        if (is_high) begin
          touch_armed_next    = 1'b0;
          sys_reset           = in_low_power_next;
          hold_active_next    = 1'b0;
          hold_remaining_next = '0;
        end
      end
      buvs_pkg::OP_TICK: begin
        if (hold_active) begin
          if (hold_remaining <= buvs_pkg::TIMEOUT_W'(1)) begin
            hold_active_next    = 1'b0;
            hold_remaining_next = '0;
            hold_expired_next   = 1'b1;
          end else begin
            hold_remaining_next = hold_remaining - buvs_pkg::TIMEOUT_W'(1);
          end
        end
      end
      buvs_pkg::OP_TOUCH: begin
        if (touch_armed) begin
          if (in_low_power) begin
            sys_reset = 1'b1;
          end else begin
            hold_active_next    = 1'b1;
            hold_remaining_next = cfg.timeout_ticks;
          end
        end
      end
      default: begin
      end
    endcase

    if (sys_reset) begin
      in_low_power_next   = 1'b0;
      hold_active_next    = 1'b0;
      hold_remaining_next = '0;
      hold_expired_next   = 1'b0;
      touch_armed_next    = 1'b0;
    end

    res.enter_low_power = entered;
    res.system_reset    = sys_reset;
    res.timer_running   = hold_active_next;
    res.low_power_mode  = in_low_power_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_low_power   <= 1'b0;
      hold_active    <= 1'b0;
      hold_remaining <= '0;
      hold_expired   <= 1'b0;
      touch_armed    <= 1'b0;
    end else if (step) begin
      in_low_power   <= in_low_power_next;
      hold_active    <= hold_active_next;
      hold_remaining <= hold_remaining_next;
      hold_expired   <= hold_expired_next;
      touch_armed    <= touch_armed_next;
    end
  end

endmodule

/* test/tb_battery_undervoltage_supervisor.sv */
// ----------------------------------------------------------------------------
// tb_battery_undervoltage_supervisor
// Self-checking bench for the battery undervoltage supervisor. A short table
// of directed rows (edge thresholds, expiry, low power entry, both kinds of
// reset request, inverted thresholds) is followed by random traffic in several
// register settings. Every result transaction is checked against the row's typed
// result where it has one, else against a cycle-free model of the supervisor state.
// ----------------------------------------------------------------------------
module tb_battery_undervoltage_supervisor;
  timeunit 1ns;
  timeprecision 1ps;

  // unmapped register index
  localparam logic [buvs_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int RANDOM_PHASES = 7;
  localparam int ITEMS_PER_PHASE = 107;

  typedef struct packed {
    logic                           is_write;
    logic [1:0]                     code;      // operation or register index
    logic [buvs_pkg::CFG_DAT_W-1:0] value;     // measurement or write data
    logic                           known;     // expected result typed into the row
    buvs_pkg::result_t              want;
  } row_t;

  logic clk;
  logic rst;

  buvs_in_if  in_ch ();
  buvs_out_if out_ch ();
  buvs_cfg_if cfg_ch ();

  battery_undervoltage_supervisor DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // supervisor model state
  buvs_pkg::cfg_t                 cfg_shadow = '{buvs_pkg::LOW_THRESHOLD_RST,
                                                 buvs_pkg::HIGH_THRESHOLD_RST,
                                                 buvs_pkg::TIMEOUT_TICKS_RST};
  logic                           low_power = 1'b0;
  logic                           hold_on = 1'b0;
  logic [buvs_pkg::TIMEOUT_W-1:0] hold_left = '0;
  logic                           hold_done = 1'b0;
  logic                           touch_armed = 1'b0;

  buvs_pkg::result_t expected_results [$];
  logic              next_known = 1'b0;
  buvs_pkg::result_t next_known_want = '0;

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int writes_done = 0;
  int low_power_entries = 0;
  int reset_requests = 0;

  int ready_mode = 0;
  int ready_span = 0;

  function automatic buvs_pkg::result_t step_supervisor(buvs_pkg::op_t op,
                                                       logic [buvs_pkg::MEAS_W-1:0] meas);
    buvs_pkg::result_t r;
    logic              entered;
    logic              req;
    entered = 1'b0;
    req = 1'b0;
    case (op)
      buvs_pkg::OP_SAMPLE: begin
        if (meas < cfg_shadow.low_threshold) begin
          touch_armed = 1'b1;
          if (!low_power) begin
            if (hold_done) begin
              low_power = 1'b1;
              entered = 1'b1;
            end
            if (!hold_on && !hold_done) begin
              hold_on = 1'b1;
              hold_left = cfg_shadow.timeout_ticks;
            end
          end
        end
        // with inverted thresholds both branches may apply, low one first
        if (meas > cfg_shadow.high_threshold) begin
          touch_armed = 1'b0;
          if (low_power) req = 1'b1;
          hold_on = 1'b0;
          hold_left = '0;
        end
      end
      buvs_pkg::OP_TICK: begin
        if (hold_on) begin
          // zero timeout acts as one
          if (hold_left <= 1) begin
            hold_on = 1'b0;
            hold_left = '0;
            hold_done = 1'b1;
          end else begin
            hold_left = hold_left - 1'b1;
          end
        end
      end
      buvs_pkg::OP_TOUCH: begin
        if (touch_armed) begin
          if (low_power) begin
            req = 1'b1;
          end else begin
            hold_on = 1'b1;
            hold_left = cfg_shadow.timeout_ticks;
          end
        end
      end
      default: ;
    endcase
    if (req) begin
      low_power = 1'b0;
      hold_on = 1'b0;
      hold_left = '0;
      hold_done = 1'b0;
      touch_armed = 1'b0;
    end
    r.enter_low_power = entered;
    r.system_reset = req;
    r.timer_running = hold_on;
    r.low_power_mode = low_power;
    return r;
  endfunction

  function automatic row_t stim(buvs_pkg::op_t op, logic [buvs_pkg::MEAS_W-1:0] meas);
    return '{1'b0, op, buvs_pkg::CFG_DAT_W'(meas), 1'b0, buvs_pkg::result_t'(4'b0000)};
  endfunction

  function automatic row_t stim_known(buvs_pkg::op_t op, logic [buvs_pkg::MEAS_W-1:0] meas,
                                      buvs_pkg::result_t want);
    return '{1'b0, op, buvs_pkg::CFG_DAT_W'(meas), 1'b1, want};
  endfunction

  function automatic row_t reg_write(logic [buvs_pkg::CFG_IDX_W-1:0] idx,
                                     logic [buvs_pkg::CFG_DAT_W-1:0] data);
    return '{1'b1, idx, data, 1'b0, buvs_pkg::result_t'(4'b0000)};
  endfunction

  // measurement biased toward the current thresholds and their edges
  function automatic logic [buvs_pkg::MEAS_W-1:0] pick_measurement();
    int k;
    k = $urandom_range(0, 9);
    if (k <= 3 && cfg_shadow.low_threshold != 0)
      return buvs_pkg::MEAS_W'($urandom_range(0, cfg_shadow.low_threshold - 1));
    if (k <= 5 && cfg_shadow.high_threshold != 16'hFFFF)
      return buvs_pkg::MEAS_W'($urandom_range(cfg_shadow.high_threshold + 1, 16'hFFFF));
    if (k == 6) return cfg_shadow.low_threshold;
    if (k == 7) return cfg_shadow.high_threshold;
    return buvs_pkg::MEAS_W'($urandom);
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("battery_undervoltage_supervisor test failed");
    $finish;
  end

  // receiver: stretches of always-ready, random, periodic and heavy stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (ready_span == 0) begin
        ready_mode = $urandom_range(0, 3);
        ready_span = $urandom_range(16, 80);
      end
      ready_span = ready_span - 1;
      case (ready_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= 1'($urandom_range(0, 1));
        2: out_ch.ready <= (ready_span % 3) != 0;
        default: out_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    buvs_pkg::result_t got;
    buvs_pkg::result_t want;
    buvs_pkg::result_t predicted;
    string             field_name [4];
    field_name = '{"enter_low_power", "system_reset", "timer_running", "low_power_mode"};
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.enter_low_power, out_ch.system_reset,
               out_ch.timer_running, out_ch.low_power_mode};
        results_seen++;
        if (got.enter_low_power) low_power_entries++;
        if (got.system_reset) reset_requests++;
        if (expected_results.size() == 0) begin
          $display("%0t: result %b with no transaction outstanding", $time, got);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          for (int f = 0; f < 4; f++) begin
            if (got[3-f] !== want[3-f]) begin
              $display("%0t: %s expected %b actual %b", $time, field_name[f],
                       want[3-f], got[3-f]);
              mismatches++;
            end
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        writes_done++;
        case (cfg_ch.index)
          buvs_pkg::CFG_LOW_THRESHOLD:
            cfg_shadow.low_threshold = cfg_ch.data[buvs_pkg::MEAS_W-1:0];
          buvs_pkg::CFG_HIGH_THRESHOLD:
            cfg_shadow.high_threshold = cfg_ch.data[buvs_pkg::MEAS_W-1:0];
          buvs_pkg::CFG_TIMEOUT_TICKS:
            cfg_shadow.timeout_ticks = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        items_sent++;
        predicted = step_supervisor(buvs_pkg::op_t'(in_ch.operation), in_ch.measurement);
        expected_results.push_back(next_known ? next_known_want : predicted);
      end
    end
  end

  task automatic idle_input(int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(buvs_pkg::op_t op, logic [buvs_pkg::MEAS_W-1:0] meas,
                           logic known, buvs_pkg::result_t want);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.measurement <= meas;
    next_known = known;
    next_known_want = want;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  task automatic wait_drained();
    idle_input(1);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(logic [buvs_pkg::CFG_IDX_W-1:0] idx,
                                logic [buvs_pkg::CFG_DAT_W-1:0] data);
    wait_drained();
    repeat (2) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    row_t                           directed_rows [29];
    logic [buvs_pkg::CFG_DAT_W-1:0] lo;
    logic [buvs_pkg::CFG_DAT_W-1:0] hi;
    logic [buvs_pkg::CFG_DAT_W-1:0] hold_ticks;
    int                             burst_left;
    int                             gap;
    int                             r;
    buvs_pkg::op_t                  op;

    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.operation = buvs_pkg::OP_NONE;
    in_ch.measurement = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = buvs_pkg::CFG_LOW_THRESHOLD;
    cfg_ch.data = '0;

    directed_rows = '{
      stim_known(buvs_pkg::OP_NONE,   16'h0000, 4'b0000),
      stim_known(buvs_pkg::OP_TICK,   16'h0000, 4'b0000),
      stim_known(buvs_pkg::OP_TOUCH,  16'h0000, 4'b0000),
      stim_known(buvs_pkg::OP_SAMPLE, 16'hFFFF, 4'b0000),
      reg_write(buvs_pkg::CFG_TIMEOUT_TICKS, 20'd2),
      stim(buvs_pkg::OP_SAMPLE, 16'h0000),   // arm, start timer
      stim(buvs_pkg::OP_TICK,   16'h0000),
      stim(buvs_pkg::OP_TICK,   16'h0000),   // expiry
      stim(buvs_pkg::OP_TOUCH,  16'h0000),   // restart after expiry
      stim(buvs_pkg::OP_SAMPLE, 16'h0000),   // low power entry, timer still running
      stim(buvs_pkg::OP_TICK,   16'h0000),
      stim(buvs_pkg::OP_TOUCH,  16'h0000),   // touch wake from low power
      stim(buvs_pkg::OP_SAMPLE, 16'h0000),
      stim(buvs_pkg::OP_TICK,   16'h0000),
      stim(buvs_pkg::OP_TICK,   16'h0000),
      stim(buvs_pkg::OP_SAMPLE, 16'h0000),   // entry with timer idle
      stim_known(buvs_pkg::OP_SAMPLE, 16'hFFFF, 4'b0100),
      stim(buvs_pkg::OP_SAMPLE, buvs_pkg::LOW_THRESHOLD_RST),
      stim(buvs_pkg::OP_SAMPLE, buvs_pkg::HIGH_THRESHOLD_RST),
      reg_write(buvs_pkg::CFG_TIMEOUT_TICKS, 20'd0),
      stim(buvs_pkg::OP_SAMPLE, buvs_pkg::LOW_THRESHOLD_RST - 1'b1),
      stim(buvs_pkg::OP_TICK,   16'h0000),   // zero timeout expires on first tick
      reg_write(buvs_pkg::CFG_LOW_THRESHOLD, 20'h0FFFF),
      reg_write(buvs_pkg::CFG_HIGH_THRESHOLD, 20'h00000),
      reg_write(CFG_SPARE, 20'hABCDE),
      // both branches: enter, then reset
      stim_known(buvs_pkg::OP_SAMPLE, 16'h1234, 4'b1100),
      stim(buvs_pkg::OP_SAMPLE, 16'hFFFF),
      stim(buvs_pkg::OP_SAMPLE, 16'h0000),
      stim(buvs_pkg::OP_NONE,   16'h5A5A)
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write)
        write_register(directed_rows[i].code, directed_rows[i].value);
      else
        send_item(buvs_pkg::op_t'(directed_rows[i].code),
                  directed_rows[i].value[buvs_pkg::MEAS_W-1:0],
                  directed_rows[i].known, directed_rows[i].want);
    end

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin
          lo = buvs_pkg::LOW_THRESHOLD_RST;
          hi = buvs_pkg::HIGH_THRESHOLD_RST;
          hold_ticks = 20'd3;
        end
        1: begin
          lo = 20'h00000; hi = 20'h0FFFF; hold_ticks = 20'd1;
        end
        2: begin
          lo = 20'h0FFFF; hi = 20'h00000; hold_ticks = 20'd5;
        end
        3: begin
          lo = buvs_pkg::CFG_DAT_W'($urandom_range(0, 32767));
          hi = lo + buvs_pkg::CFG_DAT_W'($urandom_range(0, 32768));
          hold_ticks = buvs_pkg::CFG_DAT_W'($urandom_range(1, 6));
        end
        4: begin
          lo = buvs_pkg::LOW_THRESHOLD_RST;
          hi = buvs_pkg::HIGH_THRESHOLD_RST;
          hold_ticks = 20'hFFFFF;
        end
        5: begin
          // upper data bits must be dropped for the thresholds
          lo = 20'hF8000; hi = 20'hF8000; hold_ticks = 20'd0;
        end
        default: begin
          lo = buvs_pkg::CFG_DAT_W'($urandom);
          hi = buvs_pkg::CFG_DAT_W'($urandom);
          hold_ticks = buvs_pkg::CFG_DAT_W'($urandom_range(0, 10));
        end
      endcase
      write_register(buvs_pkg::CFG_LOW_THRESHOLD, lo);
      write_register(buvs_pkg::CFG_HIGH_THRESHOLD, hi);
      write_register(buvs_pkg::CFG_TIMEOUT_TICKS, hold_ticks);

      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if (gap > 0) idle_input(gap);
        end
        burst_left--;
        r = $urandom_range(0, 99);
        op = (r < 40) ? buvs_pkg::OP_SAMPLE :
             (r < 75) ? buvs_pkg::OP_TICK :
             (r < 92) ? buvs_pkg::OP_TOUCH : buvs_pkg::OP_NONE;
        send_item(op, (op == buvs_pkg::OP_SAMPLE) ? pick_measurement() :
                                                    buvs_pkg::MEAS_W'($urandom),
                  1'b0, buvs_pkg::result_t'(4'b0000));
      end
    end

    wait_drained();
    repeat (4) @(negedge clk);

    $display("Ran %0d items and %0d register writes; %0d results checked.",
             items_sent, writes_done, results_seen);
    $display("Seen %0d low power entries and %0d reset requests; %0d mismatches.",
             low_power_entries, reset_requests, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("battery_undervoltage_supervisor test passed");
    else
      $display("battery_undervoltage_supervisor test failed");
    $finish;
  end

endmodule

/* battery_undervoltage_supervisor.f */
rtl/buvs_pkg.sv
rtl/buvs_intf.sv
rtl/buvs_core.sv
rtl/battery_undervoltage_supervisor.sv
test/tb_battery_undervoltage_supervisor.sv
